[sv/ilc_pkg.sv]
// Shared types, constants and helper functions of the irrigation and light controller.
// Used by every module, interface and the checker of the block; depends on nothing.
package ilc_pkg;

  // Widths of the channel fields.
  localparam int MODE_W      = 2;
  localparam int LUX_W       = 16;
  localparam int SOIL_RAW_W  = 12;
  localparam int CMD_W       = 3;
  localparam int PCT_W       = 7;
  localparam int POS_W       = 8;
  localparam int FAULT_W     = 3;
  localparam int MRES_W      = 2;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 27;

  // Widths of the configuration registers.
  localparam int LTHR_W      = 16;
  localparam int MTHR_W      = 7;
  localparam int DUR_W       = 16;
  localparam int INTERVAL_W  = 27;
  localparam int COOLDOWN_W  = 22;

  // Reset values of the configuration registers.
  localparam logic [LTHR_W-1:0]     LIGHT_THRESHOLD_RST      = 16'd100;
  localparam logic [MTHR_W-1:0]     MOISTURE_THRESHOLD_RST   = 7'd30;
  localparam logic [DUR_W-1:0]      PUMP_DURATION_RST        = 16'd5000;
  localparam logic [INTERVAL_W-1:0] MOISTURE_INTERVAL_RST    = 27'd3600000;
  localparam logic [COOLDOWN_W-1:0] MANUAL_COOLDOWN_RST      = 22'd60000;

  // Fixed constants of the behavior.
  localparam int                SOIL_FULL_SCALE = 4095;
  localparam int                SOIL_SHIFT      = $clog2(SOIL_FULL_SCALE + 1);
  localparam int                PCT_SCALE       = 100;
  localparam logic [TIME_W-1:0] ANIM_PERIOD_MS  = 32'd200;
  localparam logic [FAULT_W-1:0] FAULT_MAX      = 3'd7;
  localparam logic [FAULT_W-1:0] FAULT_LIMIT    = 3'd5;
  localparam int                STRIP_LENGTH_DEF = 8;

  // Item kinds.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_SAMPLE  = 2'd1,
    MODE_COMMAND = 2'd2
  } mode_t;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUMP_ON     = 3'd0,
    CMD_PUMP_OFF    = 3'd1,
    CMD_MANUAL      = 3'd2,
    CMD_LED_ON      = 3'd3,
    CMD_LED_OFF     = 3'd4,
    CMD_TOGGLE_AUTO = 3'd5
  } cmd_t;

  // Outcome of a manual moisture check.
  typedef enum logic [MRES_W-1:0] {
    MRES_NONE     = 2'd0,
    MRES_COOLDOWN = 2'd1,
    MRES_DRY      = 2'd2,
    MRES_OK       = 2'd3
  } mres_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_THRESHOLD    = 3'd0,
    REG_MOISTURE_THRESHOLD = 3'd1,
    REG_PUMP_DURATION      = 3'd2,
    REG_MOISTURE_INTERVAL  = 3'd3,
    REG_MANUAL_COOLDOWN    = 3'd4
  } reg_idx_t;

  // Configuration register set.
  typedef struct packed {
    logic [LTHR_W-1:0]     light_threshold;
    logic [MTHR_W-1:0]     moisture_threshold;
    logic [DUR_W-1:0]      pump_duration_ms;
    logic [INTERVAL_W-1:0] moisture_interval_ms;
    logic [COOLDOWN_W-1:0] manual_cooldown_ms;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [LUX_W-1:0]      light_lux;
    logic                  light_valid;
    logic [SOIL_RAW_W-1:0] soil_raw;
    logic                  climate_valid;
    logic [CMD_W-1:0]      command;
  } item_t;

  // One result.
  typedef struct packed {
    logic              pump_on;
    logic              led_enabled;
    logic              auto_enabled;
    logic              manual_override;
    logic [POS_W-1:0]  anim_position;
    logic              anim_clear;
    logic              anim_step;
    logic [PCT_W-1:0]  soil_percent;
    logic              sensor_fault;
    logic [MRES_W-1:0] manual_result;
  } result_t;

  // Control flags of the controller.
  typedef struct packed {
    logic led;
    logic manpump;
    logic pump;
    logic override;
    logic auto_en;
  } flags_t;

  // Soil percent = raw * 100 / 4095, truncated. Division by 2^12 - 1 uses
  // (x + (x >> 12) + 1) >> 12, exact for quotients well below 4096.
  function automatic logic [PCT_W-1:0] soil_to_percent(input logic [SOIL_RAW_W-1:0] raw);
    logic [SOIL_RAW_W+PCT_W-1:0] prod;
    logic [SOIL_RAW_W+PCT_W:0]   sum;
    prod = (SOIL_RAW_W+PCT_W)'(raw) * (SOIL_RAW_W+PCT_W)'(PCT_SCALE);
    sum  = (SOIL_RAW_W+PCT_W+1)'(prod) + (SOIL_RAW_W+PCT_W+1)'(prod >> SOIL_SHIFT)
         + (SOIL_RAW_W+PCT_W+1)'(1);
    return sum[SOIL_SHIFT+PCT_W-1:SOIL_SHIFT];
  endfunction

endpackage

[sv/ilc_in_if.sv]
// Input channel of the irrigation and light controller: valid/ready plus item fields.
// Depends on ilc_pkg for field widths.
interface ilc_in_if;
  logic                           valid;
  logic                           ready;
  logic [ilc_pkg::MODE_W-1:0]     mode;
  logic [ilc_pkg::LUX_W-1:0]      light_lux;
  logic                           light_valid;
  logic [ilc_pkg::SOIL_RAW_W-1:0] soil_raw;
  logic                           climate_valid;
  logic [ilc_pkg::CMD_W-1:0]      command;

  modport source (output valid, mode, light_lux, light_valid, soil_raw, climate_valid,
                  command, input ready);
  modport sink   (input valid, mode, light_lux, light_valid, soil_raw, climate_valid,
                  command, output ready);
endinterface

[sv/ilc_out_if.sv]
// Result channel of the irrigation and light controller: valid/ready plus result fields.
// Depends on ilc_pkg for field widths.
interface ilc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pump_on;
  logic                       led_enabled;
  logic                       auto_enabled;
  logic                       manual_override;
  logic [ilc_pkg::POS_W-1:0]  anim_position;
  logic                       anim_clear;
  logic                       anim_step;
  logic [ilc_pkg::PCT_W-1:0]  soil_percent;
  logic                       sensor_fault;
  logic [ilc_pkg::MRES_W-1:0] manual_result;

  modport source (output valid, pump_on, led_enabled, auto_enabled, manual_override,
                  anim_position, anim_clear, anim_step, soil_percent, sensor_fault,
                  manual_result, input ready);
  modport sink   (input valid, pump_on, led_enabled, auto_enabled, manual_override,
                  anim_position, anim_clear, anim_step, soil_percent, sensor_fault,
                  manual_result, output ready);
endinterface

[sv/ilc_cfg_if.sv]
// Configuration write channel of the irrigation and light controller.
// Depends on ilc_pkg for index and data widths.
interface ilc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ilc_pkg::CFG_IDX_W-1:0]  index;
  logic [ilc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/irrigation_light_controller_unit.sv]
// Top level of the irrigation and grow-light controller.
// Depends on ilc_pkg, the channel interfaces, ilc_cfg_regs and ilc_ctrl_core.
//
// Usage:
// The in_if channel carries requests: millisecond ticks, sensor samples and
// commands. Every request yields exactly one result on out_if, which shows
// the pump, light, mode and animation state after that request.
// The cfg_if channel writes the five configuration registers; it is always
// ready and should be written only while no request is in flight.
// A request is held in the input register and is processed when it moves
// into the result register, which makes its result valid. Throughput: one
// request per cycle while results are taken. An input register feeds the
// state update, and a result register holds its output, so a new request
// is accepted while the previous result waits on the receiver.
// When the receiver stalls, the result register holds and the input
// register fills; ready on in_if drops only when both are occupied.
// Reset (rst_n low, synchronous) clears both pipeline registers, restores
// the register defaults and sets the controller to auto mode with the pump
// and light off and the clock at zero.
module irrigation_light_controller_unit #(
  parameter int STRIP_LENGTH = ilc_pkg::STRIP_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilc_in_if.sink     in_if,
  ilc_out_if.source  out_if,
  ilc_cfg_if.sink    cfg_if
);

  ilc_pkg::cfg_t    cfg;
  ilc_pkg::item_t   in_item_r, in_item_nxt;
  logic             in_valid_r;
  ilc_pkg::result_t res;
  ilc_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_take;

  // Request moves to the result register when the output is free or draining.
  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign in_take      = in_if.valid && in_if.ready;

  assign in_item_nxt.mode          = in_if.mode;
  assign in_item_nxt.light_lux     = in_if.light_lux;
  assign in_item_nxt.light_valid   = in_if.light_valid;
  assign in_item_nxt.soil_raw      = in_if.soil_raw;
  assign in_item_nxt.climate_valid = in_if.climate_valid;
  assign in_item_nxt.command       = in_if.command;

  ilc_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  ilc_ctrl_core #(
    .STRIP_LENGTH (STRIP_LENGTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.pump_on         = out_res_r.pump_on;
  assign out_if.led_enabled     = out_res_r.led_enabled;
  assign out_if.auto_enabled    = out_res_r.auto_enabled;
  assign out_if.manual_override = out_res_r.manual_override;
  assign out_if.anim_position   = out_res_r.anim_position;
  assign out_if.anim_clear      = out_res_r.anim_clear;
  assign out_if.anim_step       = out_res_r.anim_step;
  assign out_if.soil_percent    = out_res_r.soil_percent;
  assign out_if.sensor_fault    = out_res_r.sensor_fault;
  assign out_if.manual_result   = out_res_r.manual_result;

endmodule

[sv/ilc_cfg_regs.sv]
// Configuration register file of the irrigation and light controller.
// Depends on ilc_pkg and the ilc_cfg_if channel.
module ilc_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  ilc_cfg_if.sink           cfg_if,
  output ilc_pkg::cfg_t     cfg
);

  ilc_pkg::cfg_t cfg_r;
  ilc_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  // Writes are always taken.
  assign cfg_if.ready = 1'b1;
  assign wr_en        = cfg_if.valid;
  assign cfg          = cfg_r;

  // Decode the register index; other indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_if.index)
        ilc_pkg::REG_LIGHT_THRESHOLD:
          cfg_nxt.light_threshold = cfg_if.data[ilc_pkg::LTHR_W-1:0];
        ilc_pkg::REG_MOISTURE_THRESHOLD:
          cfg_nxt.moisture_threshold = cfg_if.data[ilc_pkg::MTHR_W-1:0];
        ilc_pkg::REG_PUMP_DURATION:
          cfg_nxt.pump_duration_ms = cfg_if.data[ilc_pkg::DUR_W-1:0];
        ilc_pkg::REG_MOISTURE_INTERVAL:
          cfg_nxt.moisture_interval_ms = cfg_if.data[ilc_pkg::INTERVAL_W-1:0];
        ilc_pkg::REG_MANUAL_COOLDOWN:
          cfg_nxt.manual_cooldown_ms = cfg_if.data[ilc_pkg::COOLDOWN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register set with reset defaults.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_threshold      <= ilc_pkg::LIGHT_THRESHOLD_RST;
      cfg_r.moisture_threshold   <= ilc_pkg::MOISTURE_THRESHOLD_RST;
      cfg_r.pump_duration_ms     <= ilc_pkg::PUMP_DURATION_RST;
      cfg_r.moisture_interval_ms <= ilc_pkg::MOISTURE_INTERVAL_RST;
      cfg_r.manual_cooldown_ms   <= ilc_pkg::MANUAL_COOLDOWN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/ilc_ctrl_core.sv]
// Controller state and the single-pass update for one request.
// Depends on ilc_pkg; instantiated by irrigation_light_controller_unit.
module ilc_ctrl_core #(
  parameter int STRIP_LENGTH = ilc_pkg::STRIP_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  ilc_pkg::item_t     item,
  input  ilc_pkg::cfg_t      cfg,
  output ilc_pkg::result_t   res
);

  localparam logic [ilc_pkg::POS_W-1:0] STRIP_END = ilc_pkg::POS_W'(STRIP_LENGTH);

  logic [ilc_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic [ilc_pkg::TIME_W-1:0]  pump_start_r, pump_start_nxt;
  logic [ilc_pkg::TIME_W-1:0]  last_soil_r, last_soil_nxt;
  logic [ilc_pkg::TIME_W-1:0]  last_manual_r, last_manual_nxt;
  logic [ilc_pkg::TIME_W-1:0]  last_anim_r, last_anim_nxt;
  ilc_pkg::flags_t             flags_r, flags_nxt;
  logic [ilc_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        clearing_r, clearing_nxt;
  logic [ilc_pkg::FAULT_W-1:0] fault_r, fault_nxt;
  logic [ilc_pkg::LUX_W-1:0]   lux_r, lux_nxt;
  logic [ilc_pkg::PCT_W-1:0]   soil_r, soil_nxt;
  logic                        step;
  logic [ilc_pkg::MRES_W-1:0]  mres;

  // Next state for the request, in the order the controller applies it.
  always_comb begin : p_next
    logic [ilc_pkg::TIME_W-1:0] now_inc;
    logic [ilc_pkg::TIME_W-1:0] dur;
    logic                       low_lux;
    now_nxt         = now_r;
    pump_start_nxt  = pump_start_r;
    last_soil_nxt   = last_soil_r;
    last_manual_nxt = last_manual_r;
    last_anim_nxt   = last_anim_r;
    flags_nxt       = flags_r;
    pos_nxt         = pos_r;
    clearing_nxt    = clearing_r;
    fault_nxt       = fault_r;
    lux_nxt         = lux_r;
    soil_nxt        = soil_r;
    step            = 1'b0;
    mres            = ilc_pkg::MRES_NONE;
    now_inc         = now_r + ilc_pkg::TIME_W'(1);
    dur             = ilc_pkg::TIME_W'(cfg.pump_duration_ms);
    low_lux         = lux_r < cfg.light_threshold;

    if (fire) begin
      unique case (item.mode)
        ilc_pkg::MODE_TICK: begin
          now_nxt = now_inc;
          // A pump started by a manual check times out.
          if (flags_nxt.manpump && ((now_inc - pump_start_nxt) >= dur)) begin
            flags_nxt.pump    = 1'b0;
            flags_nxt.manpump = 1'b0;
          end
          // Automatic light control.
          if (flags_nxt.auto_en && !flags_nxt.override && (low_lux != flags_nxt.led)) begin
            flags_nxt.led = low_lux;
            pos_nxt       = '0;
            clearing_nxt  = 1'b0;
          end
          // Automatic moisture control: periodic check, then pump timeout.
          if (flags_nxt.auto_en && !flags_nxt.override && !flags_nxt.manpump) begin
            if (!flags_nxt.pump &&
                ((now_inc - last_soil_r) >= ilc_pkg::TIME_W'(cfg.moisture_interval_ms))) begin
              last_soil_nxt = now_inc;
              if (soil_r < cfg.moisture_threshold) begin
                flags_nxt.pump = 1'b1;
                pump_start_nxt = now_inc;
              end
            end
            if (flags_nxt.pump && ((now_inc - pump_start_nxt) >= dur)) begin
              flags_nxt.pump    = 1'b0;
              flags_nxt.manpump = 1'b0;
            end
          end
          // LED chase step every animation period.
          if (flags_nxt.led && ((now_inc - last_anim_r) >= ilc_pkg::ANIM_PERIOD_MS)) begin
            last_anim_nxt = now_inc;
            step          = 1'b1;
            if (!clearing_nxt) begin
              pos_nxt = pos_nxt + ilc_pkg::POS_W'(1);
              if (pos_nxt >= STRIP_END) begin
                clearing_nxt = 1'b1;
                pos_nxt      = '0;
              end
            end else begin
              clearing_nxt = 1'b0;
            end
          end
        end
        ilc_pkg::MODE_SAMPLE: begin
          if (item.light_valid) begin
            lux_nxt = item.light_lux;
          end
          // A failed climate read counts up and keeps the soil value.
          if (!item.climate_valid) begin
            if (fault_r < ilc_pkg::FAULT_MAX) begin
              fault_nxt = fault_r + ilc_pkg::FAULT_W'(1);
            end
          end else begin
            fault_nxt = '0;
            soil_nxt  = ilc_pkg::soil_to_percent(item.soil_raw);
          end
        end
        ilc_pkg::MODE_COMMAND: begin
          unique case (item.command)
            ilc_pkg::CMD_PUMP_ON: begin
              flags_nxt.pump     = 1'b1;
              pump_start_nxt     = now_r;
              flags_nxt.override = 1'b1;
            end
            ilc_pkg::CMD_PUMP_OFF: begin
              flags_nxt.pump     = 1'b0;
              flags_nxt.manpump  = 1'b0;
              flags_nxt.override = 1'b1;
            end
            ilc_pkg::CMD_MANUAL: begin
              if ((now_r - last_manual_r) < ilc_pkg::TIME_W'(cfg.manual_cooldown_ms)) begin
                mres = ilc_pkg::MRES_COOLDOWN;
              end else begin
                last_manual_nxt = now_r;
                if (soil_r < cfg.moisture_threshold) begin
                  flags_nxt.pump    = 1'b1;
                  flags_nxt.manpump = 1'b1;
                  pump_start_nxt    = now_r;
                  mres              = ilc_pkg::MRES_DRY;
                end else begin
                  mres = ilc_pkg::MRES_OK;
                end
              end
            end
            ilc_pkg::CMD_LED_ON: begin
              flags_nxt.led = 1'b1;
              pos_nxt       = '0;
              clearing_nxt  = 1'b0;
            end
            ilc_pkg::CMD_LED_OFF: begin
              flags_nxt.led = 1'b0;
              pos_nxt       = '0;
              clearing_nxt  = 1'b0;
            end
            ilc_pkg::CMD_TOGGLE_AUTO: begin
              flags_nxt.auto_en  = !flags_r.auto_en;
              flags_nxt.override = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Result fields reflect the state after the request.
  always_comb begin
    res.pump_on         = flags_nxt.pump;
    res.led_enabled     = flags_nxt.led;
    res.auto_enabled    = flags_nxt.auto_en;
    res.manual_override = flags_nxt.override;
    res.anim_position   = pos_nxt;
    res.anim_clear      = clearing_nxt;
    res.anim_step       = step;
    res.soil_percent    = soil_nxt;
    res.sensor_fault    = fault_nxt > ilc_pkg::FAULT_LIMIT;
    res.manual_result   = mres;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      pump_start_r  <= '0;
      last_soil_r   <= '0;
      last_manual_r <= '0;
      last_anim_r   <= '0;
      flags_r       <= '{led: 1'b0, manpump: 1'b0, pump: 1'b0, override: 1'b0,
                         auto_en: 1'b1};
      pos_r         <= '0;
      clearing_r    <= 1'b0;
      fault_r       <= '0;
      lux_r         <= '0;
      soil_r        <= '0;
    end else begin
      now_r         <= now_nxt;
      pump_start_r  <= pump_start_nxt;
      last_soil_r   <= last_soil_nxt;
      last_manual_r <= last_manual_nxt;
      last_anim_r   <= last_anim_nxt;
      flags_r       <= flags_nxt;
      pos_r         <= pos_nxt;
      clearing_r    <= clearing_nxt;
      fault_r       <= fault_nxt;
      lux_r         <= lux_nxt;
      soil_r        <= soil_nxt;
    end
  end

endmodule

[sv/ilc_checker.sv]
// Port-level checks of the irrigation and light controller, bound to the top level.
// Depends on ilc_pkg and irrigation_light_controller_unit.
module ilc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       pump_on,
  input logic                       led_enabled,
  input logic [ilc_pkg::POS_W-1:0]  anim_position,
  input logic                       anim_clear,
  input logic                       anim_step,
  input logic [ilc_pkg::MRES_W-1:0] manual_result
);

  // A result waiting on the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // An animation step only happens with the light enabled.
  a_step_led: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && anim_step |-> led_enabled)
    else $error("animation step with light disabled");

  // The clearing phase always sits at the start of the strip.
  a_clear_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && anim_clear |-> anim_position == '0)
    else $error("clearing phase away from strip start");

  // A dry manual check starts the pump.
  a_dry_pump: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && manual_result == ilc_pkg::MRES_DRY |-> pump_on)
    else $error("dry manual check left the pump off");

  // Manual check results and animation steps come from different requests.
  a_mres_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && manual_result != ilc_pkg::MRES_NONE |-> !anim_step)
    else $error("manual result reported on a tick");

endmodule

bind irrigation_light_controller_unit ilc_checker u_ilc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .pump_on       (out_if.pump_on),
  .led_enabled   (out_if.led_enabled),
  .anim_position (out_if.anim_position),
  .anim_clear    (out_if.anim_clear),
  .anim_step     (out_if.anim_step),
  .manual_result (out_if.manual_result)
);

[verif/testbench.sv]
// Self-checking testbench of the irrigation and grow-light controller.
// It drives ticks, samples and commands over ilc_in_if, writes the registers over ilc_cfg_if
// and checks every status on ilc_out_if; depends on ilc_pkg and the three channel interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ilc_pkg::*;

  localparam int          STRIP_LEN   = STRIP_LENGTH_DEF;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          LONG_HOLD   = 60;
  localparam int          SETTLE      = 4;
  localparam int          SWEEP_TICKS = 200;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_UNUSED_B = 3'd7;

  // Tracks the controller state request by request and holds the statuses still due.
  class irrigation_tracker;
    cfg_t        regs;
    flags_t      flags;
    logic [31:0] now_ms, pump_t0, soil_check_t, manual_check_t, anim_t;
    logic [7:0]  chase_pos;
    logic        chase_clr;
    logic [2:0]  faults;
    logic [15:0] lux;
    logic [6:0]  soil_pct;
    logic [7:0]  strip_len;
    result_t     status_due[$];
    int          mismatches;
    int          n_checked;

    function new(int strip);
      strip_len = 8'(strip);
      regs.light_threshold      = LIGHT_THRESHOLD_RST;
      regs.moisture_threshold   = MOISTURE_THRESHOLD_RST;
      regs.pump_duration_ms     = PUMP_DURATION_RST;
      regs.moisture_interval_ms = MOISTURE_INTERVAL_RST;
      regs.manual_cooldown_ms   = MANUAL_COOLDOWN_RST;
      flags          = '0;
      flags.auto_en  = 1'b1;
      now_ms         = '0;
      pump_t0        = '0;
      soil_check_t   = '0;
      manual_check_t = '0;
      anim_t         = '0;
      chase_pos      = '0;
      chase_clr      = 1'b0;
      faults         = '0;
      lux            = '0;
      soil_pct       = '0;
      mismatches     = 0;
      n_checked      = 0;
    endfunction

    // Register writes keep only the bits of the register's width.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LIGHT_THRESHOLD:    regs.light_threshold      = data[LTHR_W-1:0];
        REG_MOISTURE_THRESHOLD: regs.moisture_threshold   = data[MTHR_W-1:0];
        REG_PUMP_DURATION:      regs.pump_duration_ms     = data[DUR_W-1:0];
        REG_MOISTURE_INTERVAL:  regs.moisture_interval_ms = data[INTERVAL_W-1:0];
        REG_MANUAL_COOLDOWN:    regs.manual_cooldown_ms   = data[COOLDOWN_W-1:0];
        default: ;
      endcase
    endfunction

    // Elapsed times are plain 32-bit differences, so the clock may wrap.
    function logic [31:0] elapsed(logic [31:0] since);
      return now_ms - since;
    endfunction

    function void start_pump();
      flags.pump = 1'b1;
      pump_t0    = now_ms;
    endfunction

    function void stop_pump();
      flags.pump    = 1'b0;
      flags.manpump = 1'b0;
    endfunction

    function void set_led(logic on);
      chase_clr = 1'b0;
      chase_pos = '0;
      flags.led = on;
    endfunction

    function logic pump_expired();
      return elapsed(pump_t0) >= 32'(regs.pump_duration_ms);
    endfunction

    // Periodic soil check and timeout of an automatically started pump.
    function void auto_water();
      if (!flags.auto_en || flags.override || flags.manpump) return;
      if (!flags.pump && elapsed(soil_check_t) >= 32'(regs.moisture_interval_ms)) begin
        soil_check_t = now_ms;
        if (soil_pct < regs.moisture_threshold) start_pump();
      end
      if (flags.pump && pump_expired()) stop_pump();
    endfunction

    // Applies one accepted request and queues the status it must produce.
    function void accept_request(item_t it);
      result_t r;
      logic    stepped;
      logic    dark;
      mres_t   mres;
      stepped = 1'b0;
      mres    = MRES_NONE;
      if (it.mode == MODE_TICK) begin
        now_ms = now_ms + 32'd1;
        if (flags.manpump && pump_expired()) stop_pump();
        if (flags.auto_en && !flags.override) begin
          dark = lux < regs.light_threshold;
          if (dark != flags.led) set_led(dark);
        end
        auto_water();
        if (flags.led && elapsed(anim_t) >= ANIM_PERIOD_MS) begin
          anim_t  = now_ms;
          stepped = 1'b1;
          if (!chase_clr) begin
            chase_pos = chase_pos + 8'd1;
            if (chase_pos >= strip_len) begin
              chase_clr = 1'b1;
              chase_pos = '0;
            end
          end else begin
            chase_clr = 1'b0;
          end
        end
      end else if (it.mode == MODE_SAMPLE) begin
        if (it.light_valid) lux = it.light_lux;
        if (!it.climate_valid) begin
          if (faults < FAULT_MAX) faults = faults + 3'd1;
        end else begin
          faults   = '0;
          soil_pct = PCT_W'((int'(it.soil_raw) * PCT_SCALE) / SOIL_FULL_SCALE);
        end
      end else if (it.mode == MODE_COMMAND) begin
        case (it.command)
          CMD_PUMP_ON: begin
            start_pump();
            flags.override = 1'b1;
          end
          CMD_PUMP_OFF: begin
            stop_pump();
            flags.override = 1'b1;
          end
          CMD_MANUAL: begin
            if (elapsed(manual_check_t) < 32'(regs.manual_cooldown_ms)) begin
              mres = MRES_COOLDOWN;
            end else begin
              manual_check_t = now_ms;
              if (soil_pct < regs.moisture_threshold) begin
                start_pump();
                flags.manpump = 1'b1;
                mres          = MRES_DRY;
              end else begin
                mres = MRES_OK;
              end
            end
          end
          CMD_LED_ON:  set_led(1'b1);
          CMD_LED_OFF: set_led(1'b0);
          CMD_TOGGLE_AUTO: begin
            flags.auto_en  = ~flags.auto_en;
            flags.override = 1'b0;
          end
          default: ;
        endcase
      end
      r.pump_on         = flags.pump;
      r.led_enabled     = flags.led;
      r.auto_enabled    = flags.auto_en;
      r.manual_override = flags.override;
      r.anim_position   = chase_pos;
      r.anim_clear      = chase_clr;
      r.anim_step       = stepped;
      r.soil_percent    = soil_pct;
      r.sensor_fault    = faults > FAULT_LIMIT;
      r.manual_result   = mres;
      status_due.push_back(r);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] MISMATCH status %0d: %s", $time, n_checked, msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) note_failure($sformatf("%s expected %0d actual %0d", name, want, got));
    endfunction

    // Compares one delivered status with the oldest one due.
    function void check_status(result_t got);
      result_t want;
      if (status_due.size() == 0) begin
        note_failure("status delivered with no request outstanding");
        return;
      end
      want = status_due.pop_front();
      compare_field("pump_on", 32'(want.pump_on), 32'(got.pump_on));
      compare_field("led_enabled", 32'(want.led_enabled), 32'(got.led_enabled));
      compare_field("auto_enabled", 32'(want.auto_enabled), 32'(got.auto_enabled));
      compare_field("manual_override", 32'(want.manual_override),
                    32'(got.manual_override));
      compare_field("anim_position", 32'(want.anim_position), 32'(got.anim_position));
      compare_field("anim_clear", 32'(want.anim_clear), 32'(got.anim_clear));
      compare_field("anim_step", 32'(want.anim_step), 32'(got.anim_step));
      compare_field("soil_percent", 32'(want.soil_percent), 32'(got.soil_percent));
      compare_field("sensor_fault", 32'(want.sensor_fault), 32'(got.sensor_fault));
      compare_field("manual_result", 32'(want.manual_result), 32'(got.manual_result));
      n_checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on = 1'b1;
  bit   long_hold_req = 1'b0;
  int   n_sent = 0;
  int   n_done = 0;
  int   quiet = 0;

  irrigation_tracker tracker = new(STRIP_LEN);

  ilc_in_if  in_if ();
  ilc_out_if out_if ();
  ilc_cfg_if cfg_if ();

  irrigation_light_controller_unit #(.STRIP_LENGTH(STRIP_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #6 clk = ~clk;

  // Observe all three channels at each edge; also watch for a stuck block.
  always @(posedge clk) begin : observe
    item_t   seen;
    result_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) tracker.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        seen.mode          = in_if.mode;
        seen.light_lux     = in_if.light_lux;
        seen.light_valid   = in_if.light_valid;
        seen.soil_raw      = in_if.soil_raw;
        seen.climate_valid = in_if.climate_valid;
        seen.command       = in_if.command;
        tracker.accept_request(seen);
      end
      if (out_if.valid && out_if.ready) begin
        got.pump_on         = out_if.pump_on;
        got.led_enabled     = out_if.led_enabled;
        got.auto_enabled    = out_if.auto_enabled;
        got.manual_override = out_if.manual_override;
        got.anim_position   = out_if.anim_position;
        got.anim_clear      = out_if.anim_clear;
        got.anim_step       = out_if.anim_step;
        got.soil_percent    = out_if.soil_percent;
        got.sensor_fault    = out_if.sensor_fault;
        got.manual_result   = out_if.manual_result;
        tracker.check_status(got);
        n_done++;
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer", quiet);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Status receiver: random stall bursts, plus one long hold when asked for.
  initial begin : receiver
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every field is random; callers override the fields that matter.
  function automatic item_t random_request();
    item_t it;
    int    pick;
    it.light_lux     = LUX_W'($urandom);
    it.light_valid   = 1'($urandom_range(0, 1));
    it.soil_raw      = SOIL_RAW_W'($urandom);
    it.climate_valid = $urandom_range(0, 99) < 85;
    if ($urandom_range(0, 19) == 0)
      it.command = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
    else
      it.command = CMD_W'($urandom_range(CMD_PUMP_ON, CMD_TOGGLE_AUTO));
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.mode = MODE_TICK;
    else if (pick < 70) it.mode = MODE_SAMPLE;
    else if (pick < 97) it.mode = MODE_COMMAND;
    else                it.mode = MODE_UNUSED;
    return it;
  endfunction

  function automatic item_t tick_request();
    item_t it;
    it      = random_request();
    it.mode = MODE_TICK;
    return it;
  endfunction

  function automatic item_t sample_request(logic [15:0] lx, logic lv, logic [11:0] raw,
                                           logic cv);
    item_t it;
    it               = random_request();
    it.mode          = MODE_SAMPLE;
    it.light_lux     = lx;
    it.light_valid   = lv;
    it.soil_raw      = raw;
    it.climate_valid = cv;
    return it;
  endfunction

  function automatic item_t command_request(logic [CMD_W-1:0] c);
    item_t it;
    it         = random_request();
    it.mode    = MODE_COMMAND;
    it.command = c;
    return it;
  endfunction

  function automatic cfg_t make_cfg(int lt, int mt, int dur, int ivl, int cool);
    cfg_t c;
    c.light_threshold      = LTHR_W'(lt);
    c.moisture_threshold   = MTHR_W'(mt);
    c.pump_duration_ms     = DUR_W'(dur);
    c.moisture_interval_ms = INTERVAL_W'(ivl);
    c.manual_cooldown_ms   = COOLDOWN_W'(cool);
    return c;
  endfunction

  // Offers one request, after an optional idle burst, and waits for its acceptance.
  // Valid stays high afterwards so that back-to-back requests need no second assignment.
  task automatic send_request(input item_t it);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.mode          <= it.mode;
    in_if.light_lux     <= it.light_lux;
    in_if.light_valid   <= it.light_valid;
    in_if.soil_raw      <= it.soil_raw;
    in_if.climate_valid <= it.climate_valid;
    in_if.command       <= it.command;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n_sent++;
  endtask

  // Stops offering, waits until every status due has come and then lets the block settle.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (n_done < n_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Writes all five registers; with junk set, the unused upper data bits are random.
  task automatic write_config(input cfg_t c, input bit junk);
    logic [CFG_DATA_W-1:0] hi;
    hi = junk ? CFG_DATA_W'($urandom) : '0;
    write_reg(REG_LIGHT_THRESHOLD, {hi[CFG_DATA_W-1:LTHR_W], c.light_threshold});
    write_reg(REG_MOISTURE_THRESHOLD, {hi[CFG_DATA_W-1:MTHR_W], c.moisture_threshold});
    write_reg(REG_PUMP_DURATION, {hi[CFG_DATA_W-1:DUR_W], c.pump_duration_ms});
    write_reg(REG_MOISTURE_INTERVAL, c.moisture_interval_ms);
    write_reg(REG_MANUAL_COOLDOWN, {hi[CFG_DATA_W-1:COOLDOWN_W], c.manual_cooldown_ms});
    cfg_if.valid <= 1'b0;
  endtask

  // Random traffic: mostly single requests, with runs of ticks and of failed climate reads.
  task automatic random_mix(input int count);
    int    k;
    int    pick;
    item_t it;
    k = 0;
    while (k < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(5, 9)) begin
          send_request(sample_request(LUX_W'($urandom), 1'($urandom_range(0, 1)),
                                      SOIL_RAW_W'($urandom), 1'b0));
          k++;
        end
      end else if (pick < 20) begin
        repeat ($urandom_range(5, 40)) begin
          send_request(tick_request());
          k++;
        end
      end else begin
        it = random_request();
        send_request(it);
        if (it.mode != MODE_UNUSED && !(it.mode == MODE_COMMAND && it.command > CMD_TOGGLE_AUTO))
          k++;
      end
    end
  endtask

  // Directed requests under the reset register values.
  task automatic directed_checks();
    send_request(sample_request(16'd0, 1'b1, 12'd0, 1'b1));
    send_request(tick_request());
    send_request(sample_request(16'hFFFF, 1'b1, 12'd4095, 1'b1));
    send_request(sample_request(16'd7, 1'b1, 12'd4094, 1'b1));
    send_request(sample_request(16'd5, 1'b0, 12'd41, 1'b1));
    send_request(tick_request());
    // A long run of failed climate reads saturates the fault count.
    repeat (7) send_request(sample_request(16'd0, 1'b0, 12'hFFF, 1'b0));
    send_request(sample_request(16'd0, 1'b0, 12'd100, 1'b1));
    send_request(command_request(CMD_MANUAL));
    send_request(command_request(CMD_PUMP_ON));
    send_request(tick_request());
    send_request(command_request(CMD_PUMP_OFF));
    send_request(command_request(CMD_LED_ON));
    send_request(command_request(CMD_LED_OFF));
    send_request(command_request(CMD_TOGGLE_AUTO));
    send_request(command_request(CMD_TOGGLE_AUTO));
    send_request(command_request(CMD_UNUSED_A));
    send_request(command_request(CMD_UNUSED_B));
    begin : unused_mode
      item_t it;
      it      = random_request();
      it.mode = MODE_UNUSED;
      send_request(it);
    end
    send_request(tick_request());
  endtask

  // Main sequence: reset, directed part, then random phases under several settings.
  initial begin : stimulus
    in_if.valid         <= 1'b0;
    in_if.mode          <= MODE_TICK;
    in_if.light_lux     <= '0;
    in_if.light_valid   <= 1'b0;
    in_if.soil_raw      <= '0;
    in_if.climate_valid <= 1'b0;
    in_if.command       <= CMD_PUMP_ON;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_LIGHT_THRESHOLD;
    cfg_if.data         <= '0;
    rst_n               <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed_checks();
    drain();

    // Short intervals and durations so that auto watering and timeouts happen often.
    // The receiver holds off for a long stretch while requests keep coming.
    write_config(make_cfg($urandom_range(1, 65535), 50, 8, 20, 15), 1'b0);
    long_hold_req = 1'b1;
    random_mix(80);
    drain();

    // Low extremes, with a pause in the middle until every status has come.
    write_config(make_cfg(0, 0, 0, 0, 0), 1'b0);
    random_mix(25);
    drain();
    random_mix(25);
    drain();

    // High extremes of the documented ranges.
    write_config(make_cfg(65535, 100, 65535, 86400000, 3600000), 1'b0);
    random_mix(50);
    drain();

    // Random small settings; upper data bits beyond each register's width are junk.
    write_config(make_cfg($urandom, $urandom_range(0, 127), $urandom_range(1, 40),
                          $urandom_range(0, 60), $urandom_range(0, 40)), 1'b1);
    random_mix(50);
    drain();

    // Final stretch without idling: light forced on, a tick run long enough to step the chase.
    idle_on = 1'b0;
    if (tracker.flags.auto_en) send_request(command_request(CMD_TOGGLE_AUTO));
    send_request(command_request(CMD_LED_ON));
    repeat (SWEEP_TICKS) send_request(tick_request());
    drain();

    if (tracker.status_due.size() != 0)
      tracker.note_failure($sformatf("%0d statuses never delivered", tracker.status_due.size()));
    if (tracker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
